FILE: hdl/source_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define STOK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("source_tokenizer_core: check failed");

// Condition in one cycle implies the consequence in the next.
`define STOK_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("source_tokenizer_core: check failed");

`else

`define STOK_ASSERT(label, clk, rst_n, prop)
`define STOK_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

FILE: hdl/stok_pkg.sv
// Types, constants and character helpers for the source tokenizer.
package stok_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned LINE_BITS   = 20;
  localparam int unsigned LENGTH_BITS = 16;

  localparam int unsigned WINDOW_DEPTH = 5;
  localparam int unsigned WIN_IDX_W    = $clog2(WINDOW_DEPTH);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef logic [23:0] field_offset_t;
  typedef logic [15:0] field_length_t;
  typedef logic [19:0] field_line_t;
  typedef logic [7:0]  char_t;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

  localparam offset_t OFFSET_ZERO  = offset_t'(0);
  localparam line_t   LINE_FIRST   = line_t'(1);
  localparam length_t LENGTH_ZERO  = length_t'(0);
  localparam length_t LENGTH_ONE   = length_t'(1);
  localparam length_t WINDOW_LIMIT = length_t'(WINDOW_DEPTH);

  localparam field_length_t FIELD_LEN_ZERO = field_length_t'(0);
  localparam field_length_t FIELD_LEN_ONE  = field_length_t'(1);
  localparam field_length_t FIELD_LEN_TWO  = field_length_t'(2);

  localparam count_t QUEUE_LEVEL_MAX   = count_t'(QUEUE_DEPTH);
  localparam count_t QUEUE_LEVEL_SPACE = count_t'(QUEUE_DEPTH - 2);

  localparam char_t CH_NUL        = 8'h00;
  localparam char_t CH_TAB        = 8'h09;
  localparam char_t CH_NEWLINE    = 8'h0A;
  localparam char_t CH_CR         = 8'h0D;
  localparam char_t CH_SPACE      = 8'h20;
  localparam char_t CH_UNDERSCORE = 8'h5F;
  localparam char_t CH_EQUAL      = 8'h3D;
  localparam char_t CH_SLASH      = 8'h2F;
  localparam char_t CH_PLUS       = 8'h2B;
  localparam char_t CH_MINUS      = 8'h2D;
  localparam char_t CH_STAR       = 8'h2A;
  localparam char_t CH_LESS       = 8'h3C;
  localparam char_t CH_GREATER    = 8'h3E;
  localparam char_t CH_LPAREN     = 8'h28;
  localparam char_t CH_RPAREN     = 8'h29;
  localparam char_t CH_LBRACE     = 8'h7B;
  localparam char_t CH_RBRACE     = 8'h7D;
  localparam char_t CH_SEMI       = 8'h3B;

  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_OP      = 4'd3,
    KIND_PUNCT   = 4'd4,
    KIND_UNKNOWN = 4'd5,
    KIND_IF      = 4'd6,
    KIND_ELSE    = 4'd7,
    KIND_WHILE   = 4'd8,
    KIND_LET     = 4'd9,
    KIND_PRINT   = 4'd10,
    KIND_INT     = 4'd11,
    KIND_BOOL    = 4'd12,
    KIND_INPUT   = 4'd13
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_EQUAL   = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_DONE    = 3'd6
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e     kind;
    field_offset_t start;
    field_length_t length;
    char_t         head_char;
    field_line_t   line;
    logic          last;
  } result_t;

  // Up to two results raised by one accepted request, in emission order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  function automatic logic is_digit(char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(char_t c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Text is right aligned: byte i of an n-byte word sits at bit 8*(n-1-i).
  function automatic logic kw_match(window_t win, length_t len, int unsigned n,
                                    logic [39:0] text);
    logic hit;
    hit = (len == length_t'(n));
    for (int unsigned i = 0; i < WINDOW_DEPTH; i++) begin
      if (i < n) begin
        if (win[i] != text[8*(n-1-i) +: 8]) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic tok_kind_e keyword_kind(window_t win, length_t len);
    tok_kind_e kind;
    kind = KIND_IDENT;
    if (kw_match(win, len, 2, 40'("if")))         kind = KIND_IF;
    else if (kw_match(win, len, 4, 40'("else")))  kind = KIND_ELSE;
    else if (kw_match(win, len, 5, 40'("while"))) kind = KIND_WHILE;
    else if (kw_match(win, len, 3, 40'("let")))   kind = KIND_LET;
    else if (kw_match(win, len, 5, 40'("print"))) kind = KIND_PRINT;
    else if (kw_match(win, len, 3, 40'("int")))   kind = KIND_INT;
    else if (kw_match(win, len, 4, 40'("bool")))  kind = KIND_BOOL;
    else if (kw_match(win, len, 5, 40'("input"))) kind = KIND_INPUT;
    return kind;
  endfunction

endpackage

FILE: hdl/stok_if.sv
// Request and token channel interfaces of the source tokenizer.
interface stok_req_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  stok_pkg::char_t     source_byte;

  modport source (output valid, output opcode, output source_byte, input ready);
  modport sink   (input valid, input opcode, input source_byte, output ready);
endinterface

interface stok_tok_if;
  logic                    valid;
  logic                    ready;
  logic [3:0]              token_kind;
  stok_pkg::field_offset_t start_offset;
  stok_pkg::field_length_t token_length;
  stok_pkg::char_t         first_char;
  stok_pkg::field_line_t   line_number;
  logic                    last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output first_char, output line_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input first_char, input line_number,
                  input last_of_run, output ready);
endinterface

FILE: hdl/stok_scanner.sv
// Scanner state machine: classifies each byte and raises up to two tokens.
module stok_scanner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  stok_pkg::char_t   source_byte_i,
  output stok_pkg::push_t   push_o
);

  stok_pkg::scan_mode_e mode_q, mode_d;
  stok_pkg::offset_t    pos_q, pos_d;
  stok_pkg::offset_t    pstart_q, pstart_d;
  stok_pkg::line_t      line_q, line_d;
  stok_pkg::line_t      pline_q, pline_d;
  stok_pkg::length_t    plen_q, plen_d;
  stok_pkg::window_t    win_q, win_d;

  stok_pkg::char_t      c;
  stok_pkg::tok_kind_e  emit_kind;
  stok_pkg::tok_kind_e  flush_kind;
  stok_pkg::result_t    flush_res, pair_res, new_res;
  logic                 flush_v, pair_v, emit_v, eof_v;
  logic                 do_start, do_extend;

  assign c = source_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stok_pkg::MODE_IDLE;
      pos_q    <= stok_pkg::OFFSET_ZERO;
      line_q   <= stok_pkg::LINE_FIRST;
      pstart_q <= stok_pkg::OFFSET_ZERO;
      plen_q   <= stok_pkg::LENGTH_ZERO;
      pline_q  <= stok_pkg::LINE_FIRST;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      pline_q  <= pline_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    line_d    = line_q;
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    pline_d   = pline_q;
    win_d     = win_q;
    flush_v   = 1'b0;
    pair_v    = 1'b0;
    emit_v    = 1'b0;
    eof_v     = 1'b0;
    do_start  = 1'b0;
    do_extend = 1'b0;
    emit_kind = stok_pkg::KIND_UNKNOWN;

    if (accept_i && (mode_q != stok_pkg::MODE_DONE)) begin
      if (opcode_i || (c == stok_pkg::CH_NUL)) begin
        // Flush what is held, then close the stream.
        flush_v   = (mode_q == stok_pkg::MODE_NUMBER) || (mode_q == stok_pkg::MODE_IDENT) ||
                    (mode_q == stok_pkg::MODE_EQUAL) || (mode_q == stok_pkg::MODE_SLASH);
        eof_v     = 1'b1;
        emit_kind = stok_pkg::KIND_EOF;
        mode_d    = stok_pkg::MODE_DONE;
      end else begin
        unique case (mode_q)
          stok_pkg::MODE_NUMBER: begin
            if (stok_pkg::is_digit(c)) begin
              do_extend = 1'b1;
            end else begin
              flush_v  = 1'b1;
              do_start = 1'b1;
            end
          end
          stok_pkg::MODE_IDENT: begin
            if (stok_pkg::is_alpha(c) || stok_pkg::is_digit(c) ||
                (c == stok_pkg::CH_UNDERSCORE)) begin
              do_extend = 1'b1;
            end else begin
              flush_v  = 1'b1;
              do_start = 1'b1;
            end
          end
          stok_pkg::MODE_EQUAL: begin
            if (c == stok_pkg::CH_EQUAL) begin
              pair_v = 1'b1;
              mode_d = stok_pkg::MODE_IDLE;
            end else begin
              flush_v  = 1'b1;
              do_start = 1'b1;
            end
          end
          stok_pkg::MODE_SLASH: begin
            if (c == stok_pkg::CH_SLASH) begin
              mode_d = stok_pkg::MODE_COMMENT;
            end else begin
              flush_v  = 1'b1;
              do_start = 1'b1;
            end
          end
          stok_pkg::MODE_COMMENT: begin
            if (c == stok_pkg::CH_NEWLINE) begin
              line_d = (&line_q) ? line_q : line_q + stok_pkg::line_t'(1);
              mode_d = stok_pkg::MODE_IDLE;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        pos_d = (&pos_q) ? pos_q : pos_q + stok_pkg::offset_t'(1);
      end

      if (do_extend) begin
        if (plen_q < stok_pkg::WINDOW_LIMIT) begin
          win_d[plen_q[stok_pkg::WIN_IDX_W-1:0]] = c;
        end
        plen_d = (&plen_q) ? plen_q : plen_q + stok_pkg::length_t'(1);
      end

      if (do_start) begin
        mode_d = stok_pkg::MODE_IDLE;
        if (stok_pkg::is_space(c)) begin
          if (c == stok_pkg::CH_NEWLINE) begin
            line_d = (&line_q) ? line_q : line_q + stok_pkg::line_t'(1);
          end
        end else if (stok_pkg::is_digit(c) || stok_pkg::is_alpha(c) ||
                     (c == stok_pkg::CH_UNDERSCORE) || (c == stok_pkg::CH_EQUAL) ||
                     (c == stok_pkg::CH_SLASH)) begin
          // Open a pending token that later bytes may extend.
          if (stok_pkg::is_digit(c))     mode_d = stok_pkg::MODE_NUMBER;
          else if (c == stok_pkg::CH_EQUAL) mode_d = stok_pkg::MODE_EQUAL;
          else if (c == stok_pkg::CH_SLASH) mode_d = stok_pkg::MODE_SLASH;
          else                           mode_d = stok_pkg::MODE_IDENT;
          pstart_d = pos_q;
          plen_d   = stok_pkg::LENGTH_ONE;
          pline_d  = line_q;
          win_d[0] = c;
        end else begin
          emit_v = 1'b1;
          case (c)
            stok_pkg::CH_PLUS, stok_pkg::CH_MINUS, stok_pkg::CH_STAR,
            stok_pkg::CH_LESS, stok_pkg::CH_GREATER:
              emit_kind = stok_pkg::KIND_OP;
            stok_pkg::CH_LPAREN, stok_pkg::CH_RPAREN, stok_pkg::CH_LBRACE,
            stok_pkg::CH_RBRACE, stok_pkg::CH_SEMI:
              emit_kind = stok_pkg::KIND_PUNCT;
            default:
              emit_kind = stok_pkg::KIND_UNKNOWN;
          endcase
        end
      end
    end
  end

  always_comb begin
    case (mode_q)
      stok_pkg::MODE_NUMBER: flush_kind = stok_pkg::KIND_NUMBER;
      stok_pkg::MODE_IDENT:  flush_kind = stok_pkg::keyword_kind(win_q, plen_q);
      default:               flush_kind = stok_pkg::KIND_OP;
    endcase
  end

  always_comb begin
    flush_res.kind      = flush_kind;
    flush_res.start     = stok_pkg::field_offset_t'(pstart_q);
    flush_res.length    = stok_pkg::field_length_t'(plen_q);
    flush_res.head_char = win_q[0];
    flush_res.line      = stok_pkg::field_line_t'(pline_q);
    flush_res.last      = 1'b0;

    pair_res.kind      = stok_pkg::KIND_OP;
    pair_res.start     = stok_pkg::field_offset_t'(pstart_q);
    pair_res.length    = stok_pkg::FIELD_LEN_TWO;
    pair_res.head_char = stok_pkg::CH_EQUAL;
    pair_res.line      = stok_pkg::field_line_t'(pline_q);
    pair_res.last      = 1'b0;

    new_res.kind      = emit_kind;
    new_res.start     = stok_pkg::field_offset_t'(pos_q);
    new_res.length    = eof_v ? stok_pkg::FIELD_LEN_ZERO : stok_pkg::FIELD_LEN_ONE;
    new_res.head_char = eof_v ? stok_pkg::CH_NUL : c;
    new_res.line      = stok_pkg::field_line_t'(line_q);
    new_res.last      = 1'b1;

    push_o.count = {1'b0, flush_v | pair_v} + {1'b0, emit_v | eof_v};
    if (flush_v) begin
      push_o.res_a = flush_res;
    end else if (pair_v) begin
      push_o.res_a = pair_res;
    end else begin
      push_o.res_a = new_res;
    end
    // The second slot only ever carries the new one-byte token or the end-of-source token.
    push_o.res_a.last = !((flush_v | pair_v) && (emit_v | eof_v));
    push_o.res_b      = new_res;
  end

endmodule

FILE: hdl/stok_outq.sv
// Result queue: takes up to two tokens a cycle, hands out one.
module stok_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stok_pkg::push_t   push_i,
  input  logic              pop_i,
  output stok_pkg::result_t head_o,
  output stok_pkg::count_t  count_o
);

  stok_pkg::result_t entry_q [stok_pkg::QUEUE_DEPTH];
  stok_pkg::ptr_t    rd_ptr_q, wr_ptr_q;
  stok_pkg::count_t  count_q;
  stok_pkg::ptr_t    wr_ptr_b;

  assign wr_ptr_b = wr_ptr_q + stok_pkg::ptr_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + stok_pkg::ptr_t'(push_i.count);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + stok_pkg::ptr_t'(1);
      end
      count_q <= count_q + stok_pkg::count_t'(push_i.count) - stok_pkg::count_t'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_ptr_b] <= push_i.res_b;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: hdl/source_tokenizer_core.sv
// Streaming source tokenizer: bytes in, token descriptors out.
//
// req_i carries one source byte (opcode 0) or end of source (opcode 1) per
// request; a zero byte also ends the source. tok_o carries token descriptors:
// kind, start offset, length, first byte and line, with a flag on the last
// token that a request raised. Whitespace and // comments raise nothing; a byte
// that closes a pending token and starts a one-byte token raises two.
// With the queue empty, the first token of a request is offered on tok_o the
// cycle after the request; a second token follows once the first is taken.
// One request is taken per cycle while req_i.ready is high; the scanner
// decides every byte combinationally from registered state, and a four-entry
// result queue takes up to two tokens per cycle and returns one.
// req_i.ready is high while at most two tokens wait, so a stalled receiver
// blocks the input once three or more tokens are queued; requests that raise
// nothing are still taken until then. Nothing is dropped. After end of source
// every request is taken and ignored until reset.
// Reset (rst_ni low, asynchronous) empties the queue, returns the scanner to
// line one, offset zero, outside any token. No clearing pass is needed.
`include "source_tokenizer_core_assert.svh"

module source_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  stok_req_if.sink   req_i,
  stok_tok_if.source tok_o
);

  stok_pkg::push_t   push;
  stok_pkg::result_t head;
  stok_pkg::count_t  q_count;
  logic              accept;
  logic              pop;
  logic              eof_pushed;

  assign req_i.ready = (q_count <= stok_pkg::QUEUE_LEVEL_SPACE);
  assign accept      = req_i.valid & req_i.ready;

  stok_scanner u_scanner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .opcode_i      (req_i.opcode),
    .source_byte_i (req_i.source_byte),
    .push_o        (push)
  );

  assign pop = tok_o.valid & tok_o.ready;

  stok_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  assign tok_o.valid        = (q_count != '0);
  assign tok_o.token_kind   = head.kind;
  assign tok_o.start_offset = head.start;
  assign tok_o.token_length = head.length;
  assign tok_o.first_char   = head.head_char;
  assign tok_o.line_number  = head.line;
  assign tok_o.last_of_run  = head.last;

  assign eof_pushed = ((push.count == 2'd2) && (push.res_b.kind == stok_pkg::KIND_EOF)) ||
                      ((push.count == 2'd1) && (push.res_a.kind == stok_pkg::KIND_EOF));

  `STOK_ASSERT(push_needs_accept, clk_i, rst_ni, (push.count != 2'd0) |-> accept)
  `STOK_ASSERT(queue_no_overflow, clk_i, rst_ni, q_count <= stok_pkg::QUEUE_LEVEL_MAX)
  `STOK_ASSERT_NEXT(quiet_after_eof, clk_i, rst_ni, eof_pushed, push.count == 2'd0)

endmodule

FILE: test/tb.sv
// Self-checking testbench for source_tokenizer_core: byte stream in, token descriptors checked.
`timescale 1ns / 1ps

module tb;
  import stok_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic  opcode;
    char_t data;
  } src_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stok_req_if req ();
  stok_tok_if tok ();

  source_tokenizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .tok_o  (tok)
  );

  src_req_t    source_q[$];
  result_t     tokens_due[$];
  logic        req_taken = 1'b0;
  logic        holdoff = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned tok_seen = 0;
  int unsigned err_cnt = 0;
  logic [31:0] rcv_cyc = '0;

  string     kw_words[8] = '{"if", "else", "while", "let", "print", "int", "bool", "input"};
  tok_kind_e kw_kinds[8] = '{KIND_IF, KIND_ELSE, KIND_WHILE, KIND_LET,
                             KIND_PRINT, KIND_INT, KIND_BOOL, KIND_INPUT};
  string     ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string     single_chars = "+-*<>(){};";

  // Scanner state as the block should hold it
  scan_mode_e mode       = MODE_IDLE;
  offset_t    pos        = OFFSET_ZERO;
  line_t      line_cnt   = LINE_FIRST;
  offset_t    pend_start = OFFSET_ZERO;
  length_t    pend_len   = LENGTH_ZERO;
  line_t      pend_line  = LINE_FIRST;
  char_t      win[WINDOW_DEPTH] = '{default: CH_NUL};

  always #6 clk_i = ~clk_i;

  function automatic logic digit_ch(char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter_ch(char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDERSCORE);
  endfunction

  function automatic void push_token(tok_kind_e k, offset_t s, length_t n, char_t c, line_t l);
    result_t r;
    r.kind      = k;
    r.start     = s;
    r.length    = n;
    r.head_char = c;
    r.line      = l;
    r.last      = 1'b0;
    tokens_due.push_back(r);
  endfunction

  function automatic void next_line();
    if (line_cnt != '1) line_cnt++;
  endfunction

  function automatic void begin_word(scan_mode_e m, char_t c);
    mode       = m;
    pend_start = pos;
    pend_len   = LENGTH_ONE;
    pend_line  = line_cnt;
    win[0]     = c;
  endfunction

  function automatic void grow_word(char_t c);
    if (pend_len < WINDOW_LIMIT) win[pend_len] = c;
    if (pend_len != '1) pend_len++;
  endfunction

  function automatic tok_kind_e word_kind();
    logic hit;
    for (int k = 0; k < 8; k++) begin
      hit = (pend_len == length_t'(kw_words[k].len()));
      for (int i = 0; i < kw_words[k].len(); i++) begin
        if (hit && win[i] != char_t'(kw_words[k][i])) hit = 1'b0;
      end
      if (hit) return kw_kinds[k];
    end
    return KIND_IDENT;
  endfunction

  // Emit whatever token is open and drop back to idle
  function automatic void flush_word();
    case (mode)
      MODE_NUMBER:             push_token(KIND_NUMBER, pend_start, pend_len, win[0], pend_line);
      MODE_IDENT:              push_token(word_kind(), pend_start, pend_len, win[0], pend_line);
      MODE_EQUAL, MODE_SLASH:  push_token(KIND_OP, pend_start, pend_len, win[0], pend_line);
      default: ;
    endcase
    mode = MODE_IDLE;
  endfunction

  function automatic void open_token(char_t c);
    tok_kind_e k;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      if (c == CH_NEWLINE) next_line();
    end else if (digit_ch(c)) begin
      begin_word(MODE_NUMBER, c);
    end else if (letter_ch(c)) begin
      begin_word(MODE_IDENT, c);
    end else if (c == CH_EQUAL) begin
      begin_word(MODE_EQUAL, c);
    end else if (c == CH_SLASH) begin
      begin_word(MODE_SLASH, c);
    end else begin
      case (c)
        CH_PLUS, CH_MINUS, CH_STAR, CH_LESS, CH_GREATER:      k = KIND_OP;
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI:  k = KIND_PUNCT;
        default:                                              k = KIND_UNKNOWN;
      endcase
      push_token(k, pos, LENGTH_ONE, c, line_cnt);
    end
  endfunction

  // Work out the tokens that one accepted request raises
  task automatic scan_byte(input logic opc, input char_t c);
    int unsigned due_start;
    result_t     r;
    due_start = tokens_due.size();
    if (mode == MODE_DONE) return;
    if (opc == OP_END || c == CH_NUL) begin
      flush_word();
      push_token(KIND_EOF, pos, LENGTH_ZERO, CH_NUL, line_cnt);
      mode = MODE_DONE;
    end else begin
      case (mode)
        MODE_NUMBER, MODE_IDENT: begin
          if (digit_ch(c) || (mode == MODE_IDENT && letter_ch(c))) begin
            grow_word(c);
          end else begin
            flush_word();
            open_token(c);
          end
        end
        MODE_EQUAL: begin
          if (c == CH_EQUAL) begin
            push_token(KIND_OP, pend_start, length_t'(2), CH_EQUAL, pend_line);
            mode = MODE_IDLE;
          end else begin
            flush_word();
            open_token(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode = MODE_COMMENT;
          end else begin
            flush_word();
            open_token(c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) begin
            next_line();
            mode = MODE_IDLE;
          end
        end
        default: begin
          mode = MODE_IDLE;
          open_token(c);
        end
      endcase
      if (pos != '1) pos++;
    end
    if (tokens_due.size() > due_start) begin
      r = tokens_due.pop_back();
      r.last = 1'b1;
      tokens_due.push_back(r);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("mismatch at token %0d: %s got %0h want %0h", tok_seen, what, got, want);
  endtask

  task automatic add_byte(input char_t c);
    src_req_t r;
    r.opcode = OP_BYTE;
    r.data   = c;
    source_q.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(char_t'(s[i]));
  endtask

  // Append one lexical fragment of the given flavour
  task automatic add_fragment(input int unsigned sel);
    string       w;
    int unsigned n;
    int unsigned k;
    int unsigned m;
    char_t       c;
    case (sel)
      0, 1: begin
        // keyword, sometimes cut short, altered or lengthened
        w = kw_words[$urandom_range(0, 7)];
        m = $urandom_range(0, 3);
        n = (m == 1) ? w.len() - 1 : w.len();
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
          add_byte((m == 2 && i == k) ? char_t'(ident_chars[$urandom_range(0, 52)])
                                      : char_t'(w[i]));
        end
        if (m == 3) add_byte(char_t'(ident_chars[$urandom_range(0, 62)]));
      end
      2, 3: begin
        add_byte(char_t'(ident_chars[$urandom_range(0, 52)]));
        repeat ($urandom_range(0, 7)) add_byte(char_t'(ident_chars[$urandom_range(0, 62)]));
      end
      4: begin
        n = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 6);
        repeat (n) add_byte(char_t'("0" + $urandom_range(0, 9)));
      end
      5, 6: begin
        repeat ($urandom_range(1, 3)) begin
          add_byte(($urandom_range(0, 5) == 0) ? CH_SPACE : char_t'(CH_TAB + $urandom_range(0, 4)));
        end
      end
      7: add_byte(char_t'(single_chars[$urandom_range(0, single_chars.len() - 1)]));
      8: begin
        add_byte(CH_EQUAL);
        if ($urandom_range(0, 1)) add_byte(CH_EQUAL);
      end
      9: begin
        add_byte(CH_SLASH);
        if ($urandom_range(0, 2) != 0) begin
          add_byte(CH_SLASH);
          repeat ($urandom_range(0, 10)) begin
            c = char_t'($urandom_range(1, 255));
            add_byte((c == CH_NEWLINE) ? CH_SPACE : c);
          end
          add_byte(CH_NEWLINE);
        end
      end
      10: add_byte(char_t'($urandom_range(1, 255)));
      11: add_byte(char_t'($urandom_range(128, 255)));
      12: add_byte(CH_SPACE);
      default: add_byte(CH_NEWLINE);
    endcase
  endtask

  // Request driver: bursts of random length, random gaps, valid held until taken
  always @(negedge clk_i) begin
    logic     offer;
    src_req_t item;
    offer       = req.valid;
    item.opcode = req.opcode;
    item.data   = req.source_byte;
    if (rst_ni) begin
      if (req_taken) begin
        void'(source_q.pop_front());
        req_taken = 1'b0;
        offer     = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (source_q.size() != 0) begin
          offer = 1'b1;
          item  = source_q[0];
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 300)
                                                     : $urandom_range(1, 12);
          end
        end
      end
    end else begin
      offer = 1'b0;
      item  = '0;
    end
    req.valid       <= offer;
    req.opcode      <= item.opcode;
    req.source_byte <= item.data;
  end

  // Token receiver: stall pattern follows bits 8:7 of the receive cycle counter
  always @(negedge clk_i) begin
    logic take;
    rcv_cyc++;
    case (rcv_cyc[8:7])
      2'd0:    take = 1'b1;
      2'd1:    take = $urandom_range(0, 1);
      2'd2:    take = (rcv_cyc % 3) != 0;
      default: take = $urandom_range(0, 3) != 0;
    endcase
    tok.ready <= take && !holdoff;
  end

  // Hold the receiver off for a long stretch so the result queue fills
  initial begin
    wait (tok_seen >= 150);
    holdoff = 1'b1;
    repeat (400) @(posedge clk_i);
    holdoff = 1'b0;
  end

  // Predict on each accepted request, check each accepted token
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        scan_byte(req.opcode, req.source_byte);
        req_taken = 1'b1;
      end
      if (tok.valid && tok.ready) begin
        tok_seen++;
        if (tokens_due.size() == 0) begin
          report("token with none due, kind", tok.token_kind, '0);
        end else begin
          want = tokens_due.pop_front();
          if (tok.token_kind !== want.kind)        report("kind", tok.token_kind, want.kind);
          if (tok.start_offset !== want.start)     report("start", tok.start_offset, want.start);
          if (tok.token_length !== want.length)    report("length", tok.token_length, want.length);
          if (tok.first_char !== want.head_char)   report("first char", tok.first_char,
                                                          want.head_char);
          if (tok.line_number !== want.line)       report("line", tok.line_number, want.line);
          if (tok.last_of_run !== want.last)       report("last", tok.last_of_run, want.last);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL source_tokenizer_core");
    $finish;
  end

  initial begin
    int unsigned base;
    src_req_t    r;

    // Directed opening: keyword, identifier, ==, number, punctuation, slash, comment
    add_text("if(x_9==0)\n{a/b;}//z\n=+");
    add_byte(8'h80);
    add_byte(8'hFF);

    base = source_q.size();
    while (source_q.size() < base + 1000) add_fragment($urandom_range(0, 13));

    base = source_q.size();
    while (source_q.size() < base + 1000) add_fragment($urandom_range(0, 13));

    // Leave an identifier open so end of source flushes it
    add_fragment(2);
    if ($urandom_range(0, 1)) begin
      r.opcode = OP_END;
      r.data   = char_t'($urandom_range(0, 255));
      source_q.push_back(r);
    end else begin
      add_byte(CH_NUL);
    end
    // Requests past end of source raise nothing
    repeat (16) begin
      r.opcode = logic'($urandom_range(0, 1));
      r.data   = char_t'($urandom_range(0, 255));
      source_q.push_back(r);
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (source_q.size() != 0 || tokens_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS source_tokenizer_core");
    end else begin
      $display("FAIL source_tokenizer_core");
    end
    $finish;
  end

endmodule
